@@ sv/complex_stack_magnitude_sort_top_macros.svh @@
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef COMPLEX_STACK_MAGNITUDE_SORT_TOP_MACROS_SVH
`define COMPLEX_STACK_MAGNITUDE_SORT_TOP_MACROS_SVH

`define CSMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CSMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/csms_pkg.sv @@
`timescale 1ns / 1ps

package csms_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int POS_W           = 4;
  localparam int OP_W            = 2;
  localparam int ST_W            = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SORT = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_PUSH,
    C_POP,
    C_TAG,
    C_SWAP,
    C_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_ctrl_t;

endpackage

@@ sv/csms_mag.sv @@
`timescale 1ns / 1ps

module csms_mag #(
  parameter int VALUE_WIDTH = csms_pkg::VALUE_WIDTH_DEF
) (
  input  logic [VALUE_WIDTH-1:0]   re,
  input  logic [VALUE_WIDTH-1:0]   im,
  output logic [2*VALUE_WIDTH-1:0] key
);

  localparam int KW = 2 * VALUE_WIDTH;

  logic [VALUE_WIDTH-1:0] a;
  logic [VALUE_WIDTH-1:0] b;
  logic [KW-1:0]          sa;
  logic [KW-1:0]          sb;

  assign a   = re[VALUE_WIDTH-1] ? (~re + 1'b1) : re;
  assign b   = im[VALUE_WIDTH-1] ? (~im + 1'b1) : im;
  assign sa  = KW'(a) * KW'(a);
  assign sb  = KW'(b) * KW'(b);
  assign key = sa + sb;

endmodule

@@ sv/csms_cell.sv @@
`timescale 1ns / 1ps

module csms_cell #(
  parameter int IDX         = 0,
  parameter int DEPTH       = csms_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = csms_pkg::VALUE_WIDTH_DEF,
  localparam int KW = 2 * VALUE_WIDTH,
  localparam int TW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  csms_pkg::cell_ctrl_t   ctrl,
  input  logic [CW-1:0]          fill,
  input  logic [VALUE_WIDTH-1:0] up_re,
  input  logic [VALUE_WIDTH-1:0] up_im,
  input  logic [KW-1:0]          up_key,
  input  logic [TW-1:0]          up_tag,
  input  logic                   up_gt,
  input  logic [VALUE_WIDTH-1:0] dn_re,
  input  logic [VALUE_WIDTH-1:0] dn_im,
  input  logic [KW-1:0]          dn_key,
  input  logic [TW-1:0]          dn_tag,
  input  logic [VALUE_WIDTH-1:0] wrap_re,
  input  logic [VALUE_WIDTH-1:0] wrap_im,
  input  logic [KW-1:0]          wrap_key,
  input  logic [TW-1:0]          wrap_tag,
  output logic [VALUE_WIDTH-1:0] re_r,
  output logic [VALUE_WIDTH-1:0] im_r,
  output logic [KW-1:0]          key_r,
  output logic [TW-1:0]          tag_r,
  output logic                   gt_dn
);

  localparam logic [CW-1:0] K   = CW'(IDX);
  localparam logic [CW-1:0] KP1 = CW'(IDX + 1);
  localparam logic          PAR = 1'(IDX % 2);

  logic [VALUE_WIDTH-1:0] re_nxt;
  logic [VALUE_WIDTH-1:0] im_nxt;
  logic [KW-1:0]          key_nxt;
  logic [TW-1:0]          tag_nxt;

  // ordering key: magnitude, then bottom-up index
  assign gt_dn = {key_r, tag_r} > {dn_key, dn_tag};

  always_comb begin
    re_nxt  = re_r;
    im_nxt  = im_r;
    key_nxt = key_r;
    tag_nxt = tag_r;
    case (ctrl.op)
      csms_pkg::C_PUSH: begin
        re_nxt  = up_re;
        im_nxt  = up_im;
        key_nxt = up_key;
        tag_nxt = up_tag;
      end
      csms_pkg::C_POP: begin
        re_nxt  = dn_re;
        im_nxt  = dn_im;
        key_nxt = dn_key;
        tag_nxt = dn_tag;
      end
      csms_pkg::C_TAG: begin
        tag_nxt = TW'(fill - CW'(1) - K);
      end
      csms_pkg::C_SWAP: begin
        if ((PAR == ctrl.phase) && (KP1 < fill) && gt_dn) begin
          re_nxt  = dn_re;
          im_nxt  = dn_im;
          key_nxt = dn_key;
          tag_nxt = dn_tag;
        end else if ((PAR != ctrl.phase) && (K < fill) && up_gt) begin
          re_nxt  = up_re;
          im_nxt  = up_im;
          key_nxt = up_key;
          tag_nxt = up_tag;
        end
      end
      csms_pkg::C_ROT: begin
        if (K == fill - CW'(1)) begin
          re_nxt  = wrap_re;
          im_nxt  = wrap_im;
          key_nxt = wrap_key;
          tag_nxt = wrap_tag;
        end else begin
          re_nxt  = dn_re;
          im_nxt  = dn_im;
          key_nxt = dn_key;
          tag_nxt = dn_tag;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

endmodule

@@ sv/complex_stack_magnitude_sort_top.sv @@
`timescale 1ns / 1ps
// channel  ports   tuser         tdata (low bit up)             tlast
// in       in_*    op            value_re, value_im, zero pad   -
// out      out_*   status        out_re, out_im, position, pad  last
//
// Sort on n entries: a tag load, n odd-even transposition phases across the
// cell row, then n emits as the row rotates past the top cell; an emit waits
// while the output is stalled.
// Reset clears fill count, sequencer and output valid; cell contents are not reset.
// A stalled output holds the output register; in_tready is low during a sort
// and while a result waits that is not being taken.
`include "complex_stack_magnitude_sort_top_macros.svh"

module complex_stack_magnitude_sort_top #(
  parameter int DEPTH       = csms_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = csms_pkg::VALUE_WIDTH_DEF,
  localparam int IN_DW  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * VALUE_WIDTH + csms_pkg::POS_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DW-1:0]          in_tdata,   // value_re, value_im
  input  logic [csms_pkg::OP_W-1:0] in_tuser,   // op
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_DW-1:0]         out_tdata,  // out_re, out_im, position
  output logic [csms_pkg::ST_W-1:0] out_tuser,  // status
  output logic                      out_tlast   // last
);

  localparam int KW = 2 * VALUE_WIDTH;
  localparam int TW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = csms_pkg::POS_W;

  typedef enum logic [1:0] {S_IDLE, S_SORT, S_EMIT} state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic                   out_valid_r, out_valid_nxt;
  csms_pkg::status_t      out_status_r, out_status_nxt;
  logic [VALUE_WIDTH-1:0] out_re_r, out_re_nxt;
  logic [VALUE_WIDTH-1:0] out_im_r, out_im_nxt;
  logic [PW-1:0]          out_pos_r, out_pos_nxt;
  logic                   out_last_r, out_last_nxt;

  csms_pkg::cell_ctrl_t   cctrl;
  csms_pkg::op_t          in_op;
  logic [VALUE_WIDTH-1:0] in_re;
  logic [VALUE_WIDTH-1:0] in_im;
  logic [KW-1:0]          in_key;
  logic                   out_free;
  logic                   full;
  logic                   empty;

  logic [VALUE_WIDTH-1:0] c_re  [DEPTH];
  logic [VALUE_WIDTH-1:0] c_im  [DEPTH];
  logic [KW-1:0]          c_key [DEPTH];
  logic [TW-1:0]          c_tag [DEPTH];
  logic                   c_gt  [DEPTH];

  assign in_op  = csms_pkg::op_t'(in_tuser);
  assign in_re  = in_tdata[VALUE_WIDTH-1:0];
  assign in_im  = in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign full   = (fill_r == CW'(DEPTH));
  assign empty  = (fill_r == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DW'({out_pos_r, out_im_r, out_re_r});

  csms_mag #(.VALUE_WIDTH(VALUE_WIDTH)) u_mag (
    .re  (in_re),
    .im  (in_im),
    .key (in_key)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] ure, uim, dre, dim;
    logic [KW-1:0]          ukey, dkey;
    logic [TW-1:0]          utag, dtag;
    logic                   ugt;

    if (k == 0) begin : g_top
      assign ure  = in_re;
      assign uim  = in_im;
      assign ukey = in_key;
      assign utag = '0;
      assign ugt  = 1'b0;
    end else begin : g_mid
      assign ure  = c_re[k-1];
      assign uim  = c_im[k-1];
      assign ukey = c_key[k-1];
      assign utag = c_tag[k-1];
      assign ugt  = c_gt[k-1];
    end

    if (k == DEPTH - 1) begin : g_end
      assign dre  = c_re[0];
      assign dim  = c_im[0];
      assign dkey = c_key[0];
      assign dtag = c_tag[0];
    end else begin : g_link
      assign dre  = c_re[k+1];
      assign dim  = c_im[k+1];
      assign dkey = c_key[k+1];
      assign dtag = c_tag[k+1];
    end

    csms_cell #(
      .IDX         (k),
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cctrl),
      .fill     (fill_r),
      .up_re    (ure),
      .up_im    (uim),
      .up_key   (ukey),
      .up_tag   (utag),
      .up_gt    (ugt),
      .dn_re    (dre),
      .dn_im    (dim),
      .dn_key   (dkey),
      .dn_tag   (dtag),
      .wrap_re  (c_re[0]),
      .wrap_im  (c_im[0]),
      .wrap_key (c_key[0]),
      .wrap_tag (c_tag[0]),
      .re_r     (c_re[k]),
      .im_r     (c_im[k]),
      .key_r    (c_key[k]),
      .tag_r    (c_tag[k]),
      .gt_dn    (c_gt[k])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_re_nxt     = out_re_r;
    out_im_nxt     = out_im_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    cctrl.op       = csms_pkg::C_HOLD;
    cctrl.phase    = cnt_r[0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (in_op)
            csms_pkg::OP_PUSH: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_status_nxt = csms_pkg::ST_FULL;
                out_re_nxt     = '0;
                out_im_nxt     = '0;
                out_pos_nxt    = '0;
              end else begin
                out_status_nxt = csms_pkg::ST_OK;
                out_re_nxt     = in_re;
                out_im_nxt     = in_im;
                out_pos_nxt    = PW'(fill_r);
                cctrl.op       = csms_pkg::C_PUSH;
                fill_nxt       = fill_r + CW'(1);
              end
            end
            csms_pkg::OP_POP: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (empty) begin
                out_status_nxt = csms_pkg::ST_EMPTY;
                out_re_nxt     = '0;
                out_im_nxt     = '0;
                out_pos_nxt    = '0;
              end else begin
                out_status_nxt = csms_pkg::ST_OK;
                out_re_nxt     = c_re[0];
                out_im_nxt     = c_im[0];
                out_pos_nxt    = PW'(fill_r - CW'(1));
                cctrl.op       = csms_pkg::C_POP;
                fill_nxt       = fill_r - CW'(1);
              end
            end
            csms_pkg::OP_SORT: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = csms_pkg::ST_EMPTY;
                out_re_nxt     = '0;
                out_im_nxt     = '0;
                out_pos_nxt    = '0;
              end else begin
                cctrl.op  = csms_pkg::C_TAG;
                state_nxt = S_SORT;
                cnt_nxt   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SORT: begin
        cctrl.op = csms_pkg::C_SWAP;
        if (cnt_r == fill_r - CW'(1)) begin
          state_nxt = S_EMIT;
          cnt_nxt   = fill_r - CW'(1);
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = csms_pkg::ST_OK;
          out_re_nxt     = c_re[0];
          out_im_nxt     = c_im[0];
          out_pos_nxt    = PW'(cnt_r);
          out_last_nxt   = (cnt_r == '0);
          cctrl.op       = csms_pkg::C_ROT;
          if (cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_re_r     <= out_re_nxt;
    out_im_r     <= out_im_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  `CSMS_ASSERT(a_fill_bound, fill_r <= CW'(DEPTH), "fill count above depth")
  `CSMS_ASSERT(a_sort_nonempty, (state_r != S_IDLE) |-> (fill_r != '0), "sort on empty stack")
  `CSMS_ASSERT_NEXT(a_emit_from_sort, state_r == S_IDLE, state_r != S_EMIT, "emit without sort")
  `CSMS_ASSERT_NEXT(a_fill_hold, state_r != S_IDLE, $stable(fill_r), "fill moved in sort")
  `CSMS_ASSERT_NEXT(a_emit_last, (state_r == S_EMIT) && out_free, out_last_r == ($past(cnt_r) == '0), "emit last mark wrong")

endmodule

@@ sim/csms_stack_checker.sv @@
`timescale 1ns / 1ps

module csms_stack_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // value_re, value_im
  input  logic [1:0]  in_tuser,   // op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // out_re, out_im, position, pad
  input  logic [1:0]  out_tuser,  // status
  input  logic        out_tlast,  // last
  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          full_drops,
  output int          empty_hits
);
  import csms_pkg::*;

  localparam int VW    = VALUE_WIDTH_DEF;
  localparam int DEPTH = DEPTH_DEF;
  localparam int PW    = POS_W;

  typedef struct {
    status_t       st;
    logic [VW-1:0] re;
    logic [VW-1:0] im;
    logic [PW-1:0] pos;
    logic          last;
  } stack_result_t;

  stack_result_t results_due[$];
  logic [VW-1:0] slot_re [DEPTH];
  logic [VW-1:0] slot_im [DEPTH];
  int            fill;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic logic [2*VW:0] mag_sq(input logic [VW-1:0] re, input logic [VW-1:0] im);
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    a = re[VW-1] ? -re : re;
    b = im[VW-1] ? -im : im;
    return (2*VW+1)'(a) * (2*VW+1)'(a) + (2*VW+1)'(b) * (2*VW+1)'(b);
  endfunction

  task automatic add_result(input status_t st, input logic [VW-1:0] re,
                            input logic [VW-1:0] im, input int pos, input logic last);
    stack_result_t r;
    r.st   = st;
    r.re   = re;
    r.im   = im;
    r.pos  = PW'(pos);
    r.last = last;
    results_due.push_back(r);
  endtask

  task automatic apply_stack_op(input logic [1:0] code, input logic [VW-1:0] re,
                                input logic [VW-1:0] im);
    logic [VW-1:0]   ord_re  [DEPTH];
    logic [VW-1:0]   ord_im  [DEPTH];
    logic [2*VW:0]   ord_key [DEPTH];
    logic [2*VW:0]   k;
    int              i;
    int              j;
    case (code)
      OP_PUSH: begin
        if (fill >= DEPTH) begin
          add_result(ST_FULL, '0, '0, 0, 1'b1);
        end else begin
          slot_re[fill] = re;
          slot_im[fill] = im;
          add_result(ST_OK, re, im, fill, 1'b1);
          fill++;
        end
      end
      OP_POP: begin
        if (fill == 0) begin
          add_result(ST_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          fill--;
          add_result(ST_OK, slot_re[fill], slot_im[fill], fill, 1'b1);
        end
      end
      OP_SORT: begin
        if (fill == 0) begin
          add_result(ST_EMPTY, '0, '0, 0, 1'b1);
        end else begin
          // stable: equal magnitudes keep bottom-to-top order
          for (i = 0; i < fill; i++) begin
            k = mag_sq(slot_re[i], slot_im[i]);
            j = i;
            while (j > 0 && ord_key[j-1] > k) begin
              ord_re[j]  = ord_re[j-1];
              ord_im[j]  = ord_im[j-1];
              ord_key[j] = ord_key[j-1];
              j--;
            end
            ord_re[j]  = slot_re[i];
            ord_im[j]  = slot_im[i];
            ord_key[j] = k;
          end
          for (i = 0; i < fill; i++) begin
            slot_re[fill-1-i] = ord_re[i];
            slot_im[fill-1-i] = ord_im[i];
            add_result(ST_OK, ord_re[i], ord_im[i], fill - 1 - i, i == fill - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_stack_op(in_tuser, in_tdata[VW-1:0], in_tdata[2*VW-1:VW]);
      end
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (out_tuser == ST_FULL) full_drops++;
        if (out_tuser == ST_EMPTY) empty_hits++;
        if (results_due.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          want = results_due.pop_front();
          if (out_tuser !== want.st)
            report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.st));
          if (out_tdata[VW-1:0] !== want.re)
            report_mismatch($sformatf("re %h, want %h", out_tdata[VW-1:0], want.re));
          if (out_tdata[2*VW-1:VW] !== want.im)
            report_mismatch($sformatf("im %h, want %h", out_tdata[2*VW-1:VW], want.im));
          if (out_tdata[2*VW+PW-1:2*VW] !== want.pos)
            report_mismatch($sformatf("position %0d, want %0d",
                                      out_tdata[2*VW+PW-1:2*VW], want.pos));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_tlast, want.last));
        end
      end
      outstanding = results_due.size();
    end
  end

endmodule

@@ sim/complex_stack_magnitude_sort_top_tb.sv @@
`timescale 1ns / 1ps

module complex_stack_magnitude_sort_top_tb;
  import csms_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 235;
  localparam int         LONG_HOLD    = 240;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         DRAIN_LIMIT  = 5000;
  localparam int         TAIL_CYCLES  = 50;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int results_checked;
  int full_drops;
  int empty_hits;

  int  cycles    = 0;
  int  n_push    = 0;
  int  n_pop     = 0;
  int  n_sort    = 0;
  int  n_ignored = 0;
  bit  no_idle   = 1'b0;
  bit  want_hold = 1'b0;
  bit  hold_done = 1'b0;
  int  ready_gap = 0;

  always #5 clk = ~clk;

  complex_stack_magnitude_sort_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  csms_stack_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_drops      (full_drops),
    .empty_hits      (empty_hits)
  );

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      1, 2: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // bias 0 fills the stack, 1 drains it, 2 mixes
  function automatic logic [1:0] pick_op(input int bias);
    int r;
    int push_lim;
    int pop_lim;
    r        = $urandom_range(0, 99);
    push_lim = (bias == 0) ? 70 : (bias == 1) ? 25 : 45;
    pop_lim  = (bias == 0) ? 82 : (bias == 1) ? 85 : 75;
    if (r < 5) return OP_UNUSED;
    if (r < push_lim) return OP_PUSH;
    if (r < pop_lim) return OP_POP;
    return OP_SORT;
  endfunction

  task automatic send_item(input logic [1:0] code, input logic [15:0] re,
                           input logic [15:0] im);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= {im, re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (code)
      OP_PUSH: n_push++;
      OP_POP:  n_pop++;
      OP_SORT: n_sort++;
      default: n_ignored++;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_gap = 0;
    end else if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      ready_gap = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      ready_gap = pick_gap();
      out_tready <= (ready_gap == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
      $display("complex_stack_magnitude_sort_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int random_done;
    int burst_no;
    int burst_len;
    int bias;
    int k;
    int drain;
    logic [1:0] code;
    random_done = 0;
    burst_no    = 0;
    drain       = 0;

    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_POP,    16'h0000, 16'h0000);
    send_item(OP_SORT,   16'h0000, 16'h0000);
    send_item(OP_UNUSED, 16'h1234, 16'h5678);
    send_item(OP_PUSH,   16'h8000, 16'h8000);
    send_item(OP_PUSH,   16'h7fff, 16'h7fff);
    send_item(OP_PUSH,   16'h0000, 16'h0000);
    send_item(OP_PUSH,   16'h0001, 16'hffff);
    send_item(OP_PUSH,   16'hffff, 16'h0001);
    send_item(OP_PUSH,   16'h8000, 16'h0000);
    send_item(OP_PUSH,   16'h0000, 16'h8000);
    send_item(OP_PUSH,   16'h7fff, 16'h8000);
    send_item(OP_PUSH,   16'h00ff, 16'hff00);
    send_item(OP_PUSH,   16'h5555, 16'haaaa);
    send_item(OP_PUSH,   16'haaaa, 16'h5555);
    send_item(OP_PUSH,   16'h0003, 16'h0004);
    send_item(OP_PUSH,   16'h0004, 16'h0003);
    send_item(OP_PUSH,   16'h0005, 16'h0000);
    send_item(OP_PUSH,   16'h0000, 16'hfffb);
    send_item(OP_PUSH,   16'h0000, 16'h0000);
    send_item(OP_PUSH,   16'h0101, 16'h0202);
    send_item(OP_UNUSED, 16'hffff, 16'hffff);
    send_item(OP_SORT,   16'hffff, 16'hffff);
    send_item(OP_POP,    16'hffff, 16'hffff);
    send_item(OP_POP,    16'h0000, 16'h0000);

    while (random_done < RANDOM_ITEMS) begin
      burst_len = $urandom_range(20, 40);
      bias      = $urandom_range(0, 2);
      no_idle   = (burst_no % 4 == 2);
      for (k = 0; k < burst_len && random_done < RANDOM_ITEMS; k++) begin
        if (random_done >= RANDOM_ITEMS / 2) want_hold = 1'b1;
        code = pick_op(bias);
        send_item(code, pick_value(), pick_value());
        if (code != OP_UNUSED) random_done++;
      end
      burst_no++;
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("items: %0d push, %0d pop, %0d sort, %0d unused op; %0d results checked",
             n_push, n_pop, n_sort, n_ignored, results_checked);
    $display("full-stack drops: %0d, empty-stack replies: %0d, results never seen: %0d",
             full_drops, empty_hits, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("complex_stack_magnitude_sort_top regression: pass");
    end else begin
      $display("complex_stack_magnitude_sort_top regression: fail");
    end
    $finish;
  end

endmodule
